// ===== rtl/dfcp_pkg.sv =====
// Shared types, character codes and helpers for the drill-file command parser.
`timescale 1ns / 1ps

package dfcp_pkg;

    localparam int TOOL_COUNT   = 10;
    localparam int TARGET_SLOTS = 256;

    localparam int TOOL_W  = $clog2(TOOL_COUNT + 1);
    localparam int TPROD_W = $clog2(TOOL_COUNT * 10 + 10);
    localparam int TIDX_W  = (TOOL_COUNT > 1) ? $clog2(TOOL_COUNT) : 1;
    localparam int SLOT_W  = $clog2(TARGET_SLOTS);

    localparam logic [7:0] CHR_0   = 8'h30;
    localparam logic [7:0] CHR_9   = 8'h39;
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_DOT = 8'h2E;
    localparam logic [7:0] CHR_C   = 8'h43;
    localparam logic [7:0] CHR_G   = 8'h47;
    localparam logic [7:0] CHR_M   = 8'h4D;
    localparam logic [7:0] CHR_T   = 8'h54;
    localparam logic [7:0] CHR_X   = 8'h58;
    localparam logic [7:0] CHR_Y   = 8'h59;

    localparam logic [15:0] GCODE_ABS = 16'd90;
    localparam logic [15:0] GCODE_REL = 16'd91;

    localparam logic [2:0] CAUSE_C     = 3'd0;
    localparam logic [2:0] CAUSE_G     = 3'd1;
    localparam logic [2:0] CAUSE_M     = 3'd2;
    localparam logic [2:0] CAUSE_T     = 3'd3;
    localparam logic [2:0] CAUSE_XY    = 3'd4;
    localparam logic [2:0] CAUSE_TBIG  = 3'd5;
    localparam logic [2:0] CAUSE_TZERO = 3'd6;

    typedef enum logic [3:0] {
        TK_DIGIT,
        TK_DOT,
        TK_CR,
        TK_C,
        TK_G,
        TK_M,
        TK_T,
        TK_X,
        TK_Y,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } tok_t;

    typedef enum logic [2:0] {
        KIND_POS   = 3'd0,
        KIND_SIZE  = 3'd1,
        KIND_GCODE = 3'd2,
        KIND_MCODE = 3'd3,
        KIND_TSEL  = 3'd4,
        KIND_ERR   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  error_cause;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [7:0]  slot_index;
        logic [3:0]  tool_id;
        logic [15:0] code_value;
    } res_t;

    // value * 10 + digit, wrapping at 16 bits
    function automatic logic [15:0] acc10(logic [15:0] v, logic [3:0] d);
        return (v << 3) + (v << 1) + {12'b0, d};
    endfunction

endpackage

// ===== rtl/drill_file_command_parser.sv =====
// Top level of the drill-file command parser: byte front end, parser back end.
// A byte accepted by the front end is classified into the token queue; the parser
// takes it in a single step while the result queue is not full, and any result
// it yields shows on the result ports (empty low) as soon as it is queued.
// Throughput: one byte per cycle while the result queue is not full.
// Reset (rst_n low, asynchronous): queues empty, positions, slot counter, mode,
// error latch and the tool size table cleared.
`timescale 1ns / 1ps

module drill_file_command_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [2:0]  error_cause,
    output logic [15:0] x_coord,
    output logic [15:0] y_coord,
    output logic [7:0]  slot_index,
    output logic [3:0]  tool_id,
    output logic [15:0] code_value
);

    logic           tok_valid;
    logic           tok_pop;
    dfcp_pkg::tok_t tok;
    dfcp_pkg::res_t res;

    dfcp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    dfcp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign kind        = res.kind;
    assign error_cause = res.error_cause;
    assign x_coord     = res.x_coord;
    assign y_coord     = res.y_coord;
    assign slot_index  = res.slot_index;
    assign tool_id     = res.tool_id;
    assign code_value  = res.code_value;

endmodule

// ===== rtl/dfcp_front.sv =====
// Front end: classifies received bytes into tokens and queues them for the parser.
`timescale 1ns / 1ps

module dfcp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        rx_byte,
    output logic              tok_valid,
    output dfcp_pkg::tok_t    tok,
    input  logic              tok_pop
);

    dfcp_pkg::tok_t tok_new;
    dfcp_pkg::tok_t tq_mem_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           wr_en;
    logic           rd_en;

    always_comb
    begin
        tok_new.digit = rx_byte[3:0];
        tok_new.kind  = dfcp_pkg::TK_OTHER;
        if (rx_byte inside {[dfcp_pkg::CHR_0:dfcp_pkg::CHR_9]})
        begin
            tok_new.kind = dfcp_pkg::TK_DIGIT;
        end
        else
        begin
            case (rx_byte)
                dfcp_pkg::CHR_DOT: tok_new.kind = dfcp_pkg::TK_DOT;
                dfcp_pkg::CHR_CR:  tok_new.kind = dfcp_pkg::TK_CR;
                dfcp_pkg::CHR_C:   tok_new.kind = dfcp_pkg::TK_C;
                dfcp_pkg::CHR_G:   tok_new.kind = dfcp_pkg::TK_G;
                dfcp_pkg::CHR_M:   tok_new.kind = dfcp_pkg::TK_M;
                dfcp_pkg::CHR_T:   tok_new.kind = dfcp_pkg::TK_T;
                dfcp_pkg::CHR_X:   tok_new.kind = dfcp_pkg::TK_X;
                dfcp_pkg::CHR_Y:   tok_new.kind = dfcp_pkg::TK_Y;
                default:           tok_new.kind = dfcp_pkg::TK_OTHER;
            endcase
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign tok_valid = (cnt_reg != 2'd0);
    assign tok       = tq_mem_reg[rptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = tok_pop && tok_valid;

    always_comb
    begin
        wptr_next = wr_en ? !wptr_reg : wptr_reg;
        rptr_next = rd_en ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tq_mem_reg[wptr_reg] <= tok_new;
        end
    end

endmodule

// ===== rtl/dfcp_back.sv =====
// Back end: line parser state machine, tool size table and result queue.
`timescale 1ns / 1ps

module dfcp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  dfcp_pkg::tok_t    tok,
    output logic              tok_pop,
    output logic              empty,
    input  logic              pop,
    output dfcp_pkg::res_t    res
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_C,
        M_G,
        M_M,
        M_T,
        M_X,
        M_Y,
        M_SKIP
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic [15:0]                   xpos_reg, xpos_next;
    logic [15:0]                   ypos_reg, ypos_next;
    logic [15:0]                   xpend_reg, xpend_next;
    logic [15:0]                   ypend_reg, ypend_next;
    logic [15:0]                   gnum_reg, gnum_next;
    logic [15:0]                   mnum_reg, mnum_next;
    logic [dfcp_pkg::TOOL_W-1:0]   tool_reg, tool_next;
    logic                          rel_reg, rel_next;
    logic                          err_reg, err_next;
    logic                          xseen_reg, xseen_next;
    logic                          yseen_reg, yseen_next;
    logic [dfcp_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [15:0]                   tsz_reg [dfcp_pkg::TOOL_COUNT];

    logic                          tsz_we;
    logic [15:0]                   tsz_wdata;
    logic [dfcp_pkg::TIDX_W-1:0]   tidx;
    logic [15:0]                   tsz_rd;
    logic                          has_tool;
    logic [dfcp_pkg::TPROD_W-1:0]  tool_prod;
    logic [dfcp_pkg::TOOL_W+3:0]   tool_ext;
    logic [dfcp_pkg::SLOT_W+7:0]   slot_ext;
    logic [15:0]                   xnew, ynew;
    logic                          fire;
    logic                          clear_line;

    logic                          res_push;
    dfcp_pkg::res_t                res_new;
    dfcp_pkg::res_t                rq_mem_reg [2];
    logic                          rq_wptr_reg, rq_wptr_next;
    logic                          rq_rptr_reg, rq_rptr_next;
    logic [1:0]                    rq_cnt_reg, rq_cnt_next;
    logic                          rq_full;
    logic                          rq_pop;

    assign rq_full = (rq_cnt_reg == 2'd2);
    assign empty   = (rq_cnt_reg == 2'd0);
    assign res     = rq_mem_reg[rq_rptr_reg];
    assign rq_pop  = pop && !empty;

    // drop tokens once an error is latched
    assign tok_pop = tok_valid && (err_reg || !rq_full);
    assign fire    = tok_valid && !err_reg && !rq_full;

    assign has_tool  = (tool_reg != '0);
    assign tidx      = dfcp_pkg::TIDX_W'(tool_reg - dfcp_pkg::TOOL_W'(1));
    assign tsz_rd    = tsz_reg[tidx];
    assign tool_prod = (dfcp_pkg::TPROD_W'(tool_reg) << 3)
                     + (dfcp_pkg::TPROD_W'(tool_reg) << 1)
                     + dfcp_pkg::TPROD_W'(tok.digit);
    assign tool_ext  = {4'b0, tool_reg};
    assign slot_ext  = {8'b0, slot_reg};

    always_comb
    begin
        if (rel_reg)
        begin
            xnew = xpos_reg + xpend_reg;
            ynew = ypos_reg + ypend_reg;
        end
        else
        begin
            xnew = xseen_reg ? xpend_reg : xpos_reg;
            ynew = yseen_reg ? ypend_reg : ypos_reg;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        xpos_next  = xpos_reg;
        ypos_next  = ypos_reg;
        xpend_next = xpend_reg;
        ypend_next = ypend_reg;
        gnum_next  = gnum_reg;
        mnum_next  = mnum_reg;
        tool_next  = tool_reg;
        rel_next   = rel_reg;
        err_next   = err_reg;
        xseen_next = xseen_reg;
        yseen_next = yseen_reg;
        slot_next  = slot_reg;
        tsz_we     = 1'b0;
        tsz_wdata  = 16'd0;
        clear_line = 1'b0;
        res_push   = 1'b0;
        res_new    = '0;

        if (fire)
        begin
            case (mode_reg)
                M_IDLE:
                begin
                    case (tok.kind)
                        dfcp_pkg::TK_G: mode_next = M_G;
                        dfcp_pkg::TK_M: mode_next = M_M;
                        dfcp_pkg::TK_T: mode_next = M_T;
                        dfcp_pkg::TK_X:
                        begin
                            mode_next  = M_X;
                            xseen_next = 1'b1;
                        end
                        dfcp_pkg::TK_Y:
                        begin
                            mode_next  = M_Y;
                            yseen_next = 1'b1;
                        end
                        default: mode_next = M_SKIP;
                    endcase
                end

                M_C:
                begin
                    if (tok.kind == dfcp_pkg::TK_DIGIT)
                    begin
                        if (!has_tool)
                        begin
                            err_next            = 1'b1;
                            clear_line          = 1'b1;
                            res_push            = 1'b1;
                            res_new.kind        = dfcp_pkg::KIND_ERR;
                            res_new.error_cause = dfcp_pkg::CAUSE_TZERO;
                        end
                        else
                        begin
                            tsz_we    = 1'b1;
                            tsz_wdata = dfcp_pkg::acc10(tsz_rd, tok.digit);
                        end
                    end
                    else if (tok.kind == dfcp_pkg::TK_DOT)
                    begin
                        mode_next = M_C;
                    end
                    else if (tok.kind == dfcp_pkg::TK_CR)
                    begin
                        clear_line         = 1'b1;
                        res_push           = 1'b1;
                        res_new.kind       = dfcp_pkg::KIND_SIZE;
                        res_new.tool_id    = tool_ext[3:0];
                        res_new.code_value = has_tool ? tsz_rd : 16'd0;
                    end
                    else
                    begin
                        err_next            = 1'b1;
                        clear_line          = 1'b1;
                        res_push            = 1'b1;
                        res_new.kind        = dfcp_pkg::KIND_ERR;
                        res_new.error_cause = dfcp_pkg::CAUSE_C;
                    end
                end

                M_G:
                begin
                    if (tok.kind == dfcp_pkg::TK_DIGIT)
                    begin
                        gnum_next = dfcp_pkg::acc10(gnum_reg, tok.digit);
                    end
                    else if (tok.kind == dfcp_pkg::TK_CR)
                    begin
                        if (gnum_reg == dfcp_pkg::GCODE_ABS)
                        begin
                            rel_next = 1'b0;
                        end
                        else if (gnum_reg == dfcp_pkg::GCODE_REL)
                        begin
                            rel_next = 1'b1;
                        end
                        clear_line         = 1'b1;
                        res_push           = 1'b1;
                        res_new.kind       = dfcp_pkg::KIND_GCODE;
                        res_new.code_value = gnum_reg;
                    end
                    else
                    begin
                        err_next            = 1'b1;
                        clear_line          = 1'b1;
                        res_push            = 1'b1;
                        res_new.kind        = dfcp_pkg::KIND_ERR;
                        res_new.error_cause = dfcp_pkg::CAUSE_G;
                    end
                end

                M_M:
                begin
                    if (tok.kind == dfcp_pkg::TK_DIGIT)
                    begin
                        mnum_next = dfcp_pkg::acc10(mnum_reg, tok.digit);
                    end
                    else if (tok.kind == dfcp_pkg::TK_CR)
                    begin
                        clear_line         = 1'b1;
                        res_push           = 1'b1;
                        res_new.kind       = dfcp_pkg::KIND_MCODE;
                        res_new.code_value = mnum_reg;
                    end
                    else
                    begin
                        err_next            = 1'b1;
                        clear_line          = 1'b1;
                        res_push            = 1'b1;
                        res_new.kind        = dfcp_pkg::KIND_ERR;
                        res_new.error_cause = dfcp_pkg::CAUSE_M;
                    end
                end

                M_T:
                begin
                    if (tok.kind == dfcp_pkg::TK_DIGIT)
                    begin
                        if (tool_prod > dfcp_pkg::TPROD_W'(dfcp_pkg::TOOL_COUNT))
                        begin
                            err_next            = 1'b1;
                            clear_line          = 1'b1;
                            res_push            = 1'b1;
                            res_new.kind        = dfcp_pkg::KIND_ERR;
                            res_new.error_cause = dfcp_pkg::CAUSE_TBIG;
                        end
                        else
                        begin
                            tool_next = tool_prod[dfcp_pkg::TOOL_W-1:0];
                        end
                    end
                    else if (tok.kind == dfcp_pkg::TK_C)
                    begin
                        // redefining a tool starts its diameter from zero
                        mode_next = M_C;
                        tsz_we    = has_tool;
                        tsz_wdata = 16'd0;
                    end
                    else if (tok.kind == dfcp_pkg::TK_CR)
                    begin
                        clear_line      = 1'b1;
                        res_push        = 1'b1;
                        res_new.kind    = dfcp_pkg::KIND_TSEL;
                        res_new.tool_id = tool_ext[3:0];
                    end
                    else
                    begin
                        err_next            = 1'b1;
                        clear_line          = 1'b1;
                        res_push            = 1'b1;
                        res_new.kind        = dfcp_pkg::KIND_ERR;
                        res_new.error_cause = dfcp_pkg::CAUSE_T;
                    end
                end

                M_X, M_Y:
                begin
                    if (tok.kind == dfcp_pkg::TK_DIGIT)
                    begin
                        if (mode_reg == M_X)
                        begin
                            xpend_next = dfcp_pkg::acc10(xpend_reg, tok.digit);
                        end
                        else
                        begin
                            ypend_next = dfcp_pkg::acc10(ypend_reg, tok.digit);
                        end
                    end
                    else if (tok.kind == dfcp_pkg::TK_DOT)
                    begin
                        mode_next = mode_reg;
                    end
                    else if (tok.kind == dfcp_pkg::TK_Y)
                    begin
                        mode_next  = M_Y;
                        yseen_next = 1'b1;
                    end
                    else if (tok.kind == dfcp_pkg::TK_CR)
                    begin
                        xpos_next = xnew;
                        ypos_next = ynew;
                        if (slot_reg == dfcp_pkg::SLOT_W'(dfcp_pkg::TARGET_SLOTS - 1))
                        begin
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + dfcp_pkg::SLOT_W'(1);
                        end
                        clear_line         = 1'b1;
                        res_push           = 1'b1;
                        res_new.kind       = dfcp_pkg::KIND_POS;
                        res_new.x_coord    = xnew;
                        res_new.y_coord    = ynew;
                        res_new.slot_index = slot_ext[7:0];
                    end
                    else
                    begin
                        err_next            = 1'b1;
                        clear_line          = 1'b1;
                        res_push            = 1'b1;
                        res_new.kind        = dfcp_pkg::KIND_ERR;
                        res_new.error_cause = dfcp_pkg::CAUSE_XY;
                    end
                end

                M_SKIP:
                begin
                    clear_line = (tok.kind == dfcp_pkg::TK_CR);
                end

                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end

        if (clear_line)
        begin
            mode_next  = M_IDLE;
            xpend_next = 16'd0;
            ypend_next = 16'd0;
            gnum_next  = 16'd0;
            mnum_next  = 16'd0;
            tool_next  = '0;
            xseen_next = 1'b0;
            yseen_next = 1'b0;
        end
    end

    always_comb
    begin
        rq_wptr_next = res_push ? !rq_wptr_reg : rq_wptr_reg;
        rq_rptr_next = rq_pop ? !rq_rptr_reg : rq_rptr_reg;
        rq_cnt_next  = rq_cnt_reg + {1'b0, res_push} - {1'b0, rq_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            xpos_reg    <= 16'd0;
            ypos_reg    <= 16'd0;
            xpend_reg   <= 16'd0;
            ypend_reg   <= 16'd0;
            gnum_reg    <= 16'd0;
            mnum_reg    <= 16'd0;
            tool_reg    <= '0;
            rel_reg     <= 1'b0;
            err_reg     <= 1'b0;
            xseen_reg   <= 1'b0;
            yseen_reg   <= 1'b0;
            slot_reg    <= '0;
            rq_wptr_reg <= 1'b0;
            rq_rptr_reg <= 1'b0;
            rq_cnt_reg  <= 2'd0;
            for (int i = 0; i < dfcp_pkg::TOOL_COUNT; i++)
            begin
                tsz_reg[i] <= 16'd0;
            end
        end
        else
        begin
            mode_reg    <= mode_next;
            xpos_reg    <= xpos_next;
            ypos_reg    <= ypos_next;
            xpend_reg   <= xpend_next;
            ypend_reg   <= ypend_next;
            gnum_reg    <= gnum_next;
            mnum_reg    <= mnum_next;
            tool_reg    <= tool_next;
            rel_reg     <= rel_next;
            err_reg     <= err_next;
            xseen_reg   <= xseen_next;
            yseen_reg   <= yseen_next;
            slot_reg    <= slot_next;
            rq_wptr_reg <= rq_wptr_next;
            rq_rptr_reg <= rq_rptr_next;
            rq_cnt_reg  <= rq_cnt_next;
            for (int i = 0; i < dfcp_pkg::TOOL_COUNT; i++)
            begin
                if (tsz_we && (tidx == dfcp_pkg::TIDX_W'(i)))
                begin
                    tsz_reg[i] <= tsz_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            rq_mem_reg[rq_wptr_reg] <= res_new;
        end
    end

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error latch cleared without reset");

    a_no_result_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !res_push)
        else $error("result produced after error latched");

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg != 2'd3)
        else $error("result queue overflow");

    a_slot_only_on_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && (res_new.kind == dfcp_pkg::KIND_POS)) |=> $stable(slot_reg))
        else $error("slot counter moved without a position result");

    a_tool_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tool_reg <= dfcp_pkg::TOOL_W'(dfcp_pkg::TOOL_COUNT))
        else $error("tool number register out of range");

endmodule

// ===== tb/tb.sv =====
// Testbench for the drill-file command parser: line stimulus, result prediction and checking.
`timescale 1ns / 1ps

module tb;

    localparam logic [7:0] CHR_LF = 8'h0A;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_DIAMETER,
        LS_GCODE,
        LS_MCODE,
        LS_TOOL,
        LS_X,
        LS_Y,
        LS_SKIP
    } line_state_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  kind;
    logic [2:0]  error_cause;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [7:0]  slot_index;
    logic [3:0]  tool_id;
    logic [15:0] code_value;

    // parser state as seen from the byte stream
    line_state_t line_st = LS_IDLE;
    logic [15:0] x_pos = '0;
    logic [15:0] y_pos = '0;
    logic [15:0] x_pend = '0;
    logic [15:0] y_pend = '0;
    logic [15:0] g_num = '0;
    logic [15:0] m_num = '0;
    int          tool_num = 0;
    logic        rel_mode = 1'b0;
    logic        err_latched = 1'b0;
    logic        x_seen = 1'b0;
    logic        y_seen = 1'b0;
    logic [15:0] diameters [dfcp_pkg::TOOL_COUNT];
    int          slot_cnt = 0;

    dfcp_pkg::res_t line_results [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;

    drill_file_command_parser i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .error_cause (error_cause),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .slot_index  (slot_index),
        .tool_id     (tool_id),
        .code_value  (code_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [15:0] decimal_shift(logic [15:0] v, logic [3:0] d);
        return 16'(v * 10 + d);
    endfunction

    task automatic end_line();
        line_st = LS_IDLE;
        x_pend  = '0;
        y_pend  = '0;
        g_num   = '0;
        m_num   = '0;
        tool_num = 0;
        x_seen  = 1'b0;
        y_seen  = 1'b0;
    endtask

    task automatic raise_error(input logic [2:0] cause);
        dfcp_pkg::res_t r;
        r = '0;
        r.kind = dfcp_pkg::KIND_ERR;
        r.error_cause = cause;
        err_latched = 1'b1;
        end_line();
        line_results.push_back(r);
    endtask

    // advance the parser state by one byte and queue the result it yields
    task automatic parse_byte(input logic [7:0] c);
        logic           is_digit;
        logic [3:0]     digit;
        logic           tool_valid;
        dfcp_pkg::res_t r;
        is_digit   = (c >= dfcp_pkg::CHR_0) && (c <= dfcp_pkg::CHR_9);
        digit      = c[3:0];
        tool_valid = (tool_num >= 1) && (tool_num <= dfcp_pkg::TOOL_COUNT);
        r = '0;
        if (err_latched)
            return;
        case (line_st)
            LS_IDLE:
            begin
                case (c)
                    dfcp_pkg::CHR_G: line_st = LS_GCODE;
                    dfcp_pkg::CHR_M: line_st = LS_MCODE;
                    dfcp_pkg::CHR_T: line_st = LS_TOOL;
                    dfcp_pkg::CHR_X:
                    begin
                        line_st = LS_X;
                        x_seen = 1'b1;
                    end
                    dfcp_pkg::CHR_Y:
                    begin
                        line_st = LS_Y;
                        y_seen = 1'b1;
                    end
                    default: line_st = LS_SKIP;
                endcase
            end
            LS_DIAMETER:
            begin
                if (is_digit)
                begin
                    if (!tool_valid)
                        raise_error(dfcp_pkg::CAUSE_TZERO);
                    else
                        diameters[tool_num - 1] =
                            decimal_shift(diameters[tool_num - 1], digit);
                end
                else if (c == dfcp_pkg::CHR_CR)
                begin
                    r.kind = dfcp_pkg::KIND_SIZE;
                    r.tool_id = 4'(tool_num);
                    r.code_value = tool_valid ? diameters[tool_num - 1] : 16'd0;
                    end_line();
                    line_results.push_back(r);
                end
                else if (c != dfcp_pkg::CHR_DOT)
                    raise_error(dfcp_pkg::CAUSE_C);
            end
            LS_GCODE:
            begin
                if (is_digit)
                    g_num = decimal_shift(g_num, digit);
                else if (c == dfcp_pkg::CHR_CR)
                begin
                    if (g_num == dfcp_pkg::GCODE_ABS)
                        rel_mode = 1'b0;
                    else if (g_num == dfcp_pkg::GCODE_REL)
                        rel_mode = 1'b1;
                    r.kind = dfcp_pkg::KIND_GCODE;
                    r.code_value = g_num;
                    end_line();
                    line_results.push_back(r);
                end
                else
                    raise_error(dfcp_pkg::CAUSE_G);
            end
            LS_MCODE:
            begin
                if (is_digit)
                    m_num = decimal_shift(m_num, digit);
                else if (c == dfcp_pkg::CHR_CR)
                begin
                    r.kind = dfcp_pkg::KIND_MCODE;
                    r.code_value = m_num;
                    end_line();
                    line_results.push_back(r);
                end
                else
                    raise_error(dfcp_pkg::CAUSE_M);
            end
            LS_TOOL:
            begin
                if (is_digit)
                begin
                    tool_num = tool_num * 10 + digit;
                    if (tool_num > dfcp_pkg::TOOL_COUNT)
                        raise_error(dfcp_pkg::CAUSE_TBIG);
                end
                else if (c == dfcp_pkg::CHR_C)
                begin
                    // redefinition starts from a cleared diameter
                    line_st = LS_DIAMETER;
                    if (tool_valid)
                        diameters[tool_num - 1] = '0;
                end
                else if (c == dfcp_pkg::CHR_CR)
                begin
                    r.kind = dfcp_pkg::KIND_TSEL;
                    r.tool_id = 4'(tool_num);
                    end_line();
                    line_results.push_back(r);
                end
                else
                    raise_error(dfcp_pkg::CAUSE_T);
            end
            LS_X, LS_Y:
            begin
                if (is_digit)
                begin
                    if (line_st == LS_X)
                        x_pend = decimal_shift(x_pend, digit);
                    else
                        y_pend = decimal_shift(y_pend, digit);
                end
                else if (c == dfcp_pkg::CHR_Y)
                begin
                    line_st = LS_Y;
                    y_seen = 1'b1;
                end
                else if (c == dfcp_pkg::CHR_CR)
                begin
                    if (rel_mode)
                    begin
                        x_pos = x_pos + x_pend;
                        y_pos = y_pos + y_pend;
                    end
                    else
                    begin
                        if (x_seen)
                            x_pos = x_pend;
                        if (y_seen)
                            y_pos = y_pend;
                    end
                    r.kind = dfcp_pkg::KIND_POS;
                    r.x_coord = x_pos;
                    r.y_coord = y_pos;
                    r.slot_index = 8'(slot_cnt);
                    slot_cnt = (slot_cnt + 1) % dfcp_pkg::TARGET_SLOTS;
                    end_line();
                    line_results.push_back(r);
                end
                else if (c != dfcp_pkg::CHR_DOT)
                    raise_error(dfcp_pkg::CAUSE_XY);
            end
            default:
            begin
                if (c == dfcp_pkg::CHR_CR)
                    end_line();
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge that accepts the byte
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        parse_byte(b);
    endtask

    task automatic send_decimal(input int unsigned v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_digits(input int count, input bit with_dots);
        repeat (count)
        begin
            if (with_dots && $urandom_range(7) == 0)
                send_byte(dfcp_pkg::CHR_DOT);
            send_byte(dfcp_pkg::CHR_0 + 8'($urandom_range(9)));
        end
    endtask

    function automatic int digit_count();
        // mostly short fields, now and then long enough to wrap 16 bits
        return ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    endfunction

    // drop push and hold until every queued result has been popped
    task automatic wait_for_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (line_results.size() != 0);
    endtask

    task automatic random_line();
        int          pick;
        int          tool;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            tool = $urandom_range(2);
            if (tool != 1)
            begin
                send_byte(dfcp_pkg::CHR_X);
                send_digits(digit_count(), 1'b1);
            end
            if (tool != 0)
            begin
                send_byte(dfcp_pkg::CHR_Y);
                send_digits(digit_count(), 1'b1);
                if ($urandom_range(7) == 0)
                begin
                    send_byte(dfcp_pkg::CHR_Y);
                    send_digits(digit_count(), 1'b1);
                end
            end
        end
        else if (pick < 60)
        begin
            send_byte(dfcp_pkg::CHR_G);
            tool = $urandom_range(9);
            if (tool < 3)
                send_decimal(dfcp_pkg::GCODE_ABS);
            else if (tool < 6)
                send_decimal(dfcp_pkg::GCODE_REL);
            else
                send_digits(digit_count(), 1'b0);
        end
        else if (pick < 68)
        begin
            send_byte(dfcp_pkg::CHR_M);
            send_digits(digit_count(), 1'b0);
        end
        else if (pick < 82)
        begin
            send_byte(dfcp_pkg::CHR_T);
            tool = $urandom_range(dfcp_pkg::TOOL_COUNT);
            if ($urandom_range(3) == 0)
                send_byte(dfcp_pkg::CHR_0);
            if (tool != 0 || $urandom_range(1) == 1)
                send_decimal(tool);
            if ($urandom_range(1) == 1)
            begin
                send_byte(dfcp_pkg::CHR_C);
                if (tool != 0)
                    send_digits(digit_count(), 1'b1);
                else if ($urandom_range(1) == 1)
                    send_byte(dfcp_pkg::CHR_DOT);
            end
        end
        else
        begin
            do
                b = 8'($urandom_range(255));
            while (b == dfcp_pkg::CHR_G || b == dfcp_pkg::CHR_M || b == dfcp_pkg::CHR_T ||
                   b == dfcp_pkg::CHR_X || b == dfcp_pkg::CHR_Y);
            // any other lead, a stray CR too, skips up to the next CR
            send_byte(b);
            repeat ($urandom_range(0, 5))
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == dfcp_pkg::CHR_CR);
                send_byte(b);
            end
        end
        send_byte(dfcp_pkg::CHR_CR);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        dfcp_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (line_results.size() == 0)
            begin
                $error("kind: expected no transaction, got %0d", kind);
                mismatches++;
            end
            else
            begin
                want = line_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(kind));
                check_field("error_cause", 16'(want.error_cause), 16'(error_cause));
                check_field("x_coord", want.x_coord, x_coord);
                check_field("y_coord", want.y_coord, y_coord);
                check_field("slot_index", 16'(want.slot_index), 16'(slot_index));
                check_field("tool_id", 16'(want.tool_id), 16'(tool_id));
                check_field("code_value", want.code_value, code_value);
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic test_skip_lines();
        send_byte(dfcp_pkg::CHR_CR);
        send_byte(CHR_LF);
        send_byte(dfcp_pkg::CHR_CR);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(dfcp_pkg::CHR_CR);
    endtask

    task automatic test_relative_mode();
        send_byte(dfcp_pkg::CHR_G);
        send_decimal(dfcp_pkg::GCODE_REL);
        send_byte(dfcp_pkg::CHR_CR);
        // X is left out and must stay where it was
        send_byte(dfcp_pkg::CHR_Y);
        send_decimal(7);
        send_byte(dfcp_pkg::CHR_CR);
        send_byte(dfcp_pkg::CHR_G);
        send_decimal(dfcp_pkg::GCODE_ABS);
        send_byte(dfcp_pkg::CHR_CR);
    endtask

    task automatic test_tool_sizes();
        send_byte(dfcp_pkg::CHR_T);
        send_decimal(dfcp_pkg::TOOL_COUNT);
        send_byte(dfcp_pkg::CHR_C);
        send_decimal(9);
        send_byte(dfcp_pkg::CHR_CR);
        // size line for tool zero without digits
        send_byte(dfcp_pkg::CHR_T);
        send_byte(dfcp_pkg::CHR_C);
        send_byte(dfcp_pkg::CHR_CR);
    endtask

    task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                     input int count);
        int start;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < count)
            random_line();
        wait_for_results();
    endtask

    task automatic test_slot_wrap();
        int lines;
        send_idle_pct = 11;
        pop_stall_pct = 11;
        lines = dfcp_pkg::TARGET_SLOTS - slot_cnt + 2;
        repeat (lines)
        begin
            send_byte(($urandom_range(1) == 1) ? dfcp_pkg::CHR_X : dfcp_pkg::CHR_Y);
            send_digits($urandom_range(0, 1), 1'b0);
            send_byte(dfcp_pkg::CHR_CR);
        end
        wait_for_results();
    endtask

    task automatic test_error_latch();
        logic [2:0] cause;
        logic [7:0] b;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        cause = 3'($urandom_range(6));
        while (!err_latched)
        begin
            if (line_st == LS_IDLE)
            begin
                case (cause)
                    dfcp_pkg::CAUSE_C:
                    begin
                        send_byte(dfcp_pkg::CHR_T);
                        send_decimal($urandom_range(1, dfcp_pkg::TOOL_COUNT));
                        send_byte(dfcp_pkg::CHR_C);
                    end
                    dfcp_pkg::CAUSE_G:     send_byte(dfcp_pkg::CHR_G);
                    dfcp_pkg::CAUSE_M:     send_byte(dfcp_pkg::CHR_M);
                    dfcp_pkg::CAUSE_XY:
                        send_byte(($urandom_range(1) == 1) ? dfcp_pkg::CHR_X
                                                           : dfcp_pkg::CHR_Y);
                    dfcp_pkg::CAUSE_TZERO:
                    begin
                        send_byte(dfcp_pkg::CHR_T);
                        send_byte(dfcp_pkg::CHR_C);
                    end
                    default:     send_byte(dfcp_pkg::CHR_T);
                endcase
            end
            if (cause == dfcp_pkg::CAUSE_TBIG || cause == dfcp_pkg::CAUSE_TZERO)
                b = dfcp_pkg::CHR_0 + 8'($urandom_range(9));
            else
                b = ($urandom_range(1) == 1) ? dfcp_pkg::CHR_X : 8'($urandom_range(255));
            send_byte(b);
        end
        // everything after the error must be ignored
        repeat (40)
            send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        foreach (diameters[i])
            diameters[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_skip_lines();
        test_relative_mode();
        test_tool_sizes();
        wait_for_results();

        test_random_lines(0, 0, 340);
        test_random_lines(64, 0, 340);
        test_random_lines(0, 64, 340);
        test_random_lines(11, 11, 340);
        test_slot_wrap();
        test_error_latch();

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && line_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== drill_file_command_parser.f =====
rtl/dfcp_pkg.sv
rtl/dfcp_front.sv
rtl/dfcp_back.sv
rtl/drill_file_command_parser.sv
tb/tb.sv
